// ===== sv/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants
// Widths, operation codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int NODE_W    = 10;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int DEP_W     = LEVELS + 1;
    localparam int ANC_DEPTH = LEVELS * (1 << NODE_W);
    localparam int DEP_DEPTH = 1 << NODE_W;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_L0_RD, S_L0_WR,
        S_LV_RD1, S_LV_RD2, S_LV_WR,
        S_DP_INIT, S_DP_RD, S_DP_UPD, S_DP_WR,
        S_Q_DA, S_Q_DB, S_Q_SW,
        S_Q_LIFT, S_Q_LIFTU, S_Q_EQ,
        S_Q_RU, S_Q_RV, S_Q_CMP,
        S_Q_FIN, S_Q_FIN2, S_Q_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NOP, C_LOAD, C_BUILD, C_QSTART,
        C_L0_RD, C_L0_WR,
        C_LV_RD1, C_LV_RD2, C_LV_WR,
        C_DP_INIT, C_DP_RD, C_DP_UPD, C_DP_WR,
        C_Q_DA, C_Q_DB, C_Q_SW,
        C_Q_LIFT, C_Q_LIFTU, C_Q_EQ,
        C_Q_RU, C_Q_RV, C_Q_CMP,
        C_Q_FIN, C_Q_FIN2, C_OUT
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic node_last;
        logic lvl_zero;
        logic lvl_last;
        logic range_bit;
        logic load_ok;
        logic query_ok;
        logic u_eq_v;
    } t_status;

endpackage

// ===== sv/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lca_ctrl.sv =====
// ----------------------------------------------------------------------------
// lca_ctrl: sequencing state machine
// Accepts items, steps the build and query sequences, holds the result slot.
// ----------------------------------------------------------------------------
module lca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_cfg_we,
    input  lca_pkg::t_status i_status,
    output lca_pkg::t_cmd    o_cmd
);
    import lca_pkg::*;

    t_state r_state, n_state;
    logic   r_built, n_built;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = C_NOP;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_LOAD: begin
                            o_cmd = C_LOAD;
                            if (i_status.load_ok) n_built = 1'b0;
                        end
                        OP_BUILD: begin
                            o_cmd = C_BUILD;
                            if (i_status.cnt_zero) n_built = 1'b1;
                            else n_state = S_L0_RD;
                        end
                        OP_QUERY: begin
                            o_cmd   = C_QSTART;
                            n_state = (r_built && i_status.query_ok) ? S_Q_DA : S_Q_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_L0_RD: begin
                o_cmd = C_L0_RD; n_state = S_L0_WR;
            end
            S_L0_WR: begin
                o_cmd = C_L0_WR;
                n_state = i_status.node_last ? S_LV_RD1 : S_L0_RD;
            end
            S_LV_RD1: begin
                o_cmd = C_LV_RD1; n_state = S_LV_RD2;
            end
            S_LV_RD2: begin
                o_cmd = C_LV_RD2; n_state = S_LV_WR;
            end
            S_LV_WR: begin
                o_cmd = C_LV_WR;
                n_state = (i_status.node_last && i_status.lvl_last) ? S_DP_INIT : S_LV_RD1;
            end
            S_DP_INIT: begin
                o_cmd = C_DP_INIT; n_state = S_DP_RD;
            end
            S_DP_RD: begin
                o_cmd = C_DP_RD; n_state = S_DP_UPD;
            end
            S_DP_UPD: begin
                o_cmd = C_DP_UPD;
                n_state = i_status.lvl_zero ? S_DP_WR : S_DP_RD;
            end
            S_DP_WR: begin
                o_cmd = C_DP_WR;
                if (i_status.node_last) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DP_INIT;
                end
            end
            S_Q_DA: begin
                o_cmd = C_Q_DA; n_state = S_Q_DB;
            end
            S_Q_DB: begin
                o_cmd = C_Q_DB; n_state = S_Q_SW;
            end
            S_Q_SW: begin
                o_cmd = C_Q_SW; n_state = S_Q_LIFT;
            end
            S_Q_LIFT: begin
                o_cmd = C_Q_LIFT;
                if (i_status.range_bit) n_state = S_Q_LIFTU;
                else if (i_status.lvl_zero) n_state = S_Q_EQ;
            end
            S_Q_LIFTU: begin
                o_cmd = C_Q_LIFTU;
                n_state = i_status.lvl_zero ? S_Q_EQ : S_Q_LIFT;
            end
            S_Q_EQ: begin
                o_cmd = C_Q_EQ;
                n_state = i_status.u_eq_v ? S_Q_DONE : S_Q_RU;
            end
            S_Q_RU: begin
                o_cmd = C_Q_RU; n_state = S_Q_RV;
            end
            S_Q_RV: begin
                o_cmd = C_Q_RV; n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                o_cmd = C_Q_CMP;
                n_state = i_status.lvl_zero ? S_Q_FIN : S_Q_RU;
            end
            S_Q_FIN: begin
                o_cmd = C_Q_FIN; n_state = S_Q_FIN2;
            end
            S_Q_FIN2: begin
                o_cmd = C_Q_FIN2; n_state = S_Q_DONE;
            end
            S_Q_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = C_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_built = 1'b0;
    end

endmodule

// ===== sv/lca_dp.sv =====
// ----------------------------------------------------------------------------
// lca_dp: lifting datapath
// Ancestor and depth memories, node/level counters, query registers.
// ----------------------------------------------------------------------------
module lca_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lca_pkg::t_cmd              i_cmd,
    output lca_pkg::t_status           o_status,
    input  logic [lca_pkg::NODE_W-1:0] i_node_a,
    input  logic [lca_pkg::NODE_W-1:0] i_node_b,
    input  logic                       i_cfg_we,
    input  logic [lca_pkg::NODE_W-1:0] i_cfg_wdata,
    output logic [lca_pkg::NODE_W-1:0] o_ancestor
);
    import lca_pkg::*;

    localparam int AW = LVL_W + NODE_W;

    logic [NODE_W-1:0] r_cnt;
    logic [NODE_W-1:0] r_node, n_node;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [NODE_W-1:0] r_x, n_x, r_u, n_u, r_v, n_v, r_pu, n_pu;
    logic [NODE_W-1:0] r_res, n_res, r_out;
    logic [LEVELS-1:0] r_d, n_d;
    logic [DEP_W-1:0]  r_da, n_da, r_range, n_range;
    logic              r_rz, n_rz;

    logic              anc_we;
    logic [AW-1:0]     anc_waddr, anc_raddr;
    logic [NODE_W-1:0] anc_wdata, anc_rdata, y;
    logic              dep_we;
    logic [NODE_W-1:0] dep_waddr, dep_raddr;
    logic [DEP_W-1:0]  dep_wdata, dep_rdata;
    logic [LVL_W-1:0]  lvl_m1;
    logic [NODE_W-1:0] rd_node;
    logic              rd_en;

    lca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_waddr(anc_waddr), .i_wdata(anc_wdata),
        .i_raddr(anc_raddr), .o_rdata(anc_rdata)
    );

    lca_ram #(.WIDTH(DEP_W), .DEPTH(DEP_DEPTH)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr(dep_raddr), .o_rdata(dep_rdata)
    );

    assign y      = r_rz ? '0 : anc_rdata;
    assign lvl_m1 = r_lvl - 1'b1;

    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.node_last = (r_node == r_cnt);
    assign o_status.lvl_zero  = (r_lvl == '0);
    assign o_status.lvl_last  = (r_lvl == LVL_W'(LEVELS - 1));
    assign o_status.range_bit = r_range[r_lvl];
    assign o_status.load_ok   = (i_node_a != '0) && (i_node_a <= r_cnt);
    assign o_status.query_ok  = (i_node_a != '0) && (i_node_a <= r_cnt)
                                && (i_node_b != '0) && (i_node_b <= r_cnt);
    assign o_status.u_eq_v    = (r_u == r_v);
    assign o_ancestor         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= NODE_W'(1);
        end else if (i_cfg_we) begin
            r_cnt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_lvl   <= n_lvl;
        r_x     <= n_x;
        r_u     <= n_u;
        r_v     <= n_v;
        r_pu    <= n_pu;
        r_res   <= n_res;
        r_d     <= n_d;
        r_da    <= n_da;
        r_range <= n_range;
        r_rz    <= n_rz;
        if (i_cmd == C_OUT) r_out <= r_res;
    end

    always_comb begin
        n_node = r_node; n_lvl = r_lvl; n_x = r_x; n_u = r_u; n_v = r_v;
        n_pu = r_pu; n_res = r_res; n_d = r_d; n_da = r_da; n_range = r_range;
        n_rz = r_rz;
        anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0; anc_raddr = '0;
        dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0; dep_raddr = '0;
        rd_node = '0; rd_en = 1'b0;
        case (i_cmd)
            C_LOAD: begin
                anc_we    = o_status.load_ok;
                anc_waddr = {LVL_W'(0), i_node_a};
                anc_wdata = i_node_b;
            end
            C_BUILD: begin
                n_node = NODE_W'(1);
                n_lvl  = '0;
            end
            C_QSTART: begin
                n_u   = i_node_a;
                n_v   = i_node_b;
                n_res = '0;
            end
            C_L0_RD: begin
                anc_raddr = {LVL_W'(0), r_node};
                rd_node = r_node; rd_en = 1'b1;
            end
            C_L0_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {LVL_W'(0), r_node};
                anc_wdata = (r_node == NODE_W'(1) || y > r_cnt) ? '0 : y;
                if (o_status.node_last) begin
                    n_node = NODE_W'(1);
                    n_lvl  = LVL_W'(1);
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            C_LV_RD1: begin
                anc_raddr = {lvl_m1, r_node};
                rd_node = r_node; rd_en = 1'b1;
            end
            C_LV_RD2: begin
                anc_raddr = {lvl_m1, y};
                rd_node = y; rd_en = 1'b1;
            end
            C_LV_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {r_lvl, r_node};
                anc_wdata = y;
                if (o_status.node_last) begin
                    n_node = NODE_W'(1);
                    n_lvl  = r_lvl + 1'b1;
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            C_DP_INIT: begin
                n_x   = r_node;
                n_d   = '0;
                n_lvl = LVL_W'(LEVELS - 1);
            end
            C_DP_RD: begin
                anc_raddr = {r_lvl, r_x};
                rd_node = r_x; rd_en = 1'b1;
            end
            C_DP_UPD: begin
                if (y != '0) begin
                    n_x = y;
                    n_d = r_d | (LEVELS'(1) << r_lvl);
                end
                if (r_lvl != '0) n_lvl = lvl_m1;
            end
            C_DP_WR: begin
                dep_we    = 1'b1;
                dep_waddr = r_node;
                dep_wdata = {1'b0, r_d} + DEP_W'(1);
                if (!o_status.node_last) n_node = r_node + 1'b1;
            end
            C_Q_DA: dep_raddr = r_u;
            C_Q_DB: begin
                dep_raddr = r_v;
                n_da      = dep_rdata;
            end
            C_Q_SW: begin
                if (r_da < dep_rdata) begin
                    n_u     = r_v;
                    n_v     = r_u;
                    n_range = dep_rdata - r_da;
                end else begin
                    n_range = r_da - dep_rdata;
                end
                n_lvl = LVL_W'(LEVELS - 1);
            end
            C_Q_LIFT: begin
                if (o_status.range_bit) begin
                    anc_raddr = {r_lvl, r_u};
                    rd_node = r_u; rd_en = 1'b1;
                end else if (r_lvl != '0) begin
                    n_lvl = lvl_m1;
                end
            end
            C_Q_LIFTU: begin
                n_u = y;
                if (r_lvl != '0) n_lvl = lvl_m1;
            end
            C_Q_EQ: begin
                n_res = r_u;
                n_lvl = LVL_W'(LEVELS - 1);
            end
            C_Q_RU: begin
                anc_raddr = {r_lvl, r_u};
                rd_node = r_u; rd_en = 1'b1;
            end
            C_Q_RV: begin
                n_pu      = y;
                anc_raddr = {r_lvl, r_v};
                rd_node = r_v; rd_en = 1'b1;
            end
            C_Q_CMP: begin
                if (r_pu != '0 && r_pu != y) begin
                    n_u = r_pu;
                    n_v = y;
                end
                if (r_lvl != '0) n_lvl = lvl_m1;
            end
            C_Q_FIN: begin
                anc_raddr = {LVL_W'(0), r_u};
                rd_node = r_u; rd_en = 1'b1;
            end
            C_Q_FIN2: n_res = y;
            default: ;
        endcase
        if (rd_en) n_rz = (rd_node == '0);
    end

endmodule

// ===== sv/lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// lca_binary_lifting: lowest common ancestor engine, binary lifting
// Input channel (i_in_valid/o_in_ready) takes load, build and query items.
// A valid load writes one parent link. A build fills the ancestor table and
// depths through the single read port of the ancestor memory. A query reads
// both depths, lifts the deeper node, then, unless the two nodes meet, walks
// LEVELS levels with two ancestor reads each before the result is registered.
// An invalid query or one before a build answers 0. Only queries produce an
// item on the output channel (o_out_valid/i_out_ready); the output register
// holds it until taken and a new item can be accepted meanwhile, but a
// finished query waits for the register to drain. Writing i_cfg_we sets the
// node count and marks the tables stale, as does a valid load. Reset sets
// the count to 1 and clears the built flag; the tables are not cleared.
// ----------------------------------------------------------------------------
module lca_binary_lifting (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_operation,
    input  logic [lca_pkg::NODE_W-1:0] i_node_a,
    input  logic [lca_pkg::NODE_W-1:0] i_node_b,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lca_pkg::NODE_W-1:0] o_ancestor,
    input  logic                       i_cfg_we,
    input  logic [lca_pkg::NODE_W-1:0] i_cfg_wdata
);
    import lca_pkg::*;

    t_cmd    cmd;
    t_status status;

    lca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_cfg_we(i_cfg_we), .i_status(status), .o_cmd(cmd)
    );

    lca_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status),
        .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_ancestor(o_ancestor)
    );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: lca_binary_lifting testbench
// Builds random parent-linked trees at several node counts (1 through 100),
// builds the ancestor tables, and checks each query answer against a
// binary-lifting predictor held in the bench. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lca_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         MAXN      = 1023;

    typedef struct {
        logic [1:0]        op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } t_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = '0;
    logic [NODE_W-1:0] i_node_a = '0;
    logic [NODE_W-1:0] i_node_b = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [NODE_W-1:0] o_ancestor;
    logic              i_cfg_we = 1'b0;
    logic [NODE_W-1:0] i_cfg_wdata = '0;

    lca_binary_lifting uut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    t_item             item_q[$];
    logic [NODE_W-1:0] ancestor_expect[$];
    int                errors = 0;
    bit                no_idle = 1'b0;
    int                hold_kick = 0;
    int                hold_seen = 0;

    // predictor state
    int unsigned lift_tab[0:MAXN][0:LEVELS-1];
    int unsigned depth_tab[0:MAXN];
    bit          tab_built = 1'b0;
    int unsigned node_cnt = 1;

    function automatic int unsigned hop(int unsigned n, int unsigned l);
        if (n > MAXN || l >= LEVELS) return 0;
        return lift_tab[n][l];
    endfunction

    function automatic int unsigned depth_at(int unsigned n);
        return n > MAXN ? 0 : depth_tab[n];
    endfunction

    function automatic void build_lift_tables();
        int unsigned x, d, y;
        for (int i = 0; i < LEVELS; i++) lift_tab[0][i] = 0;
        for (int unsigned u = 1; u <= node_cnt; u++)
            if (u == 1 || lift_tab[u][0] > node_cnt) lift_tab[u][0] = 0;
        for (int i = 1; i < LEVELS; i++)
            for (int unsigned u = 1; u <= node_cnt; u++)
                lift_tab[u][i] = hop(hop(u, i - 1), i - 1);
        depth_tab[0] = 0;
        for (int unsigned u = 1; u <= node_cnt; u++) begin
            x = u;
            d = 0;
            for (int i = LEVELS - 1; i >= 0; i--) begin
                y = hop(x, i);
                if (y != 0) begin
                    x = y;
                    d += 1 << i;
                end
            end
            depth_tab[u] = d + 1;
        end
        tab_built = 1'b1;
    endfunction

    function automatic int unsigned common_ancestor(int unsigned u, int unsigned v);
        int unsigned t, span, pu, pv;
        if (depth_at(u) < depth_at(v)) begin
            t = u;
            u = v;
            v = t;
        end
        span = depth_at(u) - depth_at(v);
        for (int i = LEVELS - 1; i >= 0; i--)
            if ((span >> i) & 1) u = hop(u, i);
        if (u == v) return u;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            pu = hop(u, i);
            pv = hop(v, i);
            if (pu != 0 && pu != pv) begin
                u = pu;
                v = pv;
            end
        end
        return hop(u, 0);
    endfunction

    function automatic void lca_predict(t_item it);
        int unsigned r;
        case (it.op)
            OP_LOAD: begin
                if (it.a >= 1 && it.a <= node_cnt) begin
                    lift_tab[it.a][0] = it.b;
                    tab_built = 1'b0;
                end
            end
            OP_BUILD: build_lift_tables();
            OP_QUERY: begin
                r = 0;
                if (tab_built && it.a >= 1 && it.a <= node_cnt && it.b >= 1 && it.b <= node_cnt)
                    r = common_ancestor(it.a, it.b);
                ancestor_expect = {ancestor_expect, r[NODE_W-1:0]};
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        t_item it;
        bit    free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                lca_predict('{i_operation, i_node_a, i_node_b});
                free = 1'b1;
            end
            if (free) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    it = item_q.pop_front();
                    i_operation <= it.op;
                    i_node_a <= it.a;
                    i_node_b <= it.b;
                    i_in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 10);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted in cycles
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor and receiver stalls
    int sink_gap = 0;
    always @(posedge i_clk) begin
        logic [NODE_W-1:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (ancestor_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item ancestor=%0d", o_ancestor));
                end else begin
                    want = ancestor_expect.pop_front();
                    if (o_ancestor !== want)
                        flag_mismatch($sformatf("ancestor got %0d want %0d", o_ancestor, want));
                end
            end
            if (hold_kick != hold_seen || hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 10);
            end
        end
    end

    task automatic put(logic [1:0] op, int unsigned a, int unsigned b);
        t_item it;
        it = '{op, a[NODE_W-1:0], b[NODE_W-1:0]};
        item_q = {item_q, it};
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (item_q.size() != 0 || i_in_valid || ancestor_expect.size() != 0);
        repeat (60 * node_cnt + 100) @(posedge i_clk);
    endtask

    task automatic set_count(int unsigned n);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n[NODE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_cnt = n;
        tab_built = 1'b0;
    endtask

    // parent links for every node 2..n, mostly a proper tree; chain gives deep trees
    task automatic load_tree(int unsigned n, bit chain);
        int unsigned p;
        for (int unsigned u = 2; u <= n; u++) begin
            case ($urandom_range(0, 19))
                0: p = 0;
                1: p = $urandom_range(n, MAXN);
                2: p = $urandom_range(1, n);
                default: p = chain ? u - 1 : $urandom_range(1, u - 1);
            endcase
            put(OP_LOAD, u, p);
        end
        if ($urandom_range(0, 1)) put(OP_LOAD, 1, $urandom_range(0, MAXN));
    endtask

    function automatic int unsigned pick_node(int unsigned n);
        case ($urandom_range(0, 15))
            0: return 0;
            1: return $urandom_range(0, MAXN);
            2: return MAXN;
            default: return $urandom_range(1, n);
        endcase
    endfunction

    task automatic random_queries(int unsigned n, int k);
        for (int j = 0; j < k; j++) begin
            case ($urandom_range(0, 39))
                0: put(OP_UNUSED, $urandom_range(0, MAXN), $urandom_range(0, MAXN));
                1: begin
                    put(OP_LOAD, $urandom_range(2, n), $urandom_range(1, n));
                    put(OP_QUERY, pick_node(n), pick_node(n));
                    put(OP_BUILD, $urandom_range(0, MAXN), $urandom_range(0, MAXN));
                end
                2: put(OP_LOAD, $urandom_range(n + 1, MAXN), $urandom_range(0, MAXN));
                default: put(OP_QUERY, pick_node(n), pick_node(n));
            endcase
        end
    endtask

    initial begin
        int unsigned counts[$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: count of 1, query before build, unused op
        put(OP_QUERY, 1, 1);
        put(OP_UNUSED, MAXN, MAXN);
        put(OP_BUILD, 0, 0);
        put(OP_QUERY, 1, 1);
        put(OP_QUERY, 0, 1);
        put(OP_QUERY, 1, MAXN);
        drain();

        // directed: small fixed tree, ignored loads, stale table
        set_count(7);
        put(OP_LOAD, 2, 1);
        put(OP_LOAD, 3, 1);
        put(OP_LOAD, 4, 2);
        put(OP_LOAD, 5, 2);
        put(OP_LOAD, 6, 9);
        put(OP_LOAD, 7, 4);
        put(OP_LOAD, 1, 5);
        put(OP_LOAD, 0, 3);
        put(OP_LOAD, 8, 1);
        put(OP_LOAD, MAXN, MAXN);
        put(OP_BUILD, 0, 0);
        put(OP_QUERY, 7, 5);
        put(OP_QUERY, 7, 3);
        put(OP_QUERY, 6, 6);
        put(OP_QUERY, 6, 7);
        put(OP_QUERY, 4, 7);
        put(OP_QUERY, 8, 1);
        put(OP_LOAD, 3, 7);
        put(OP_QUERY, 2, 3);
        put(OP_BUILD, MAXN, MAXN);
        put(OP_QUERY, 3, 5);
        drain();

        counts = '{2, 3, 16, 40, 100, 0, 25};
        foreach (counts[k]) begin
            int unsigned n;
            n = counts[k] != 0 ? counts[k] : $urandom_range(4, 60);
            if (k == counts.size() - 1) no_idle = 1'b1;
            set_count(n);
            load_tree(n, k == 4);
            put(OP_BUILD, $urandom_range(0, MAXN), $urandom_range(0, MAXN));
            if (k == 2) begin
                drain();
                hold_kick++;
            end
            random_queries(n, 20);
            drain();
            random_queries(n, 15);
            drain();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
